// File: hdl/sal_pkg.sv
// sal_pkg: shared sizes, request and status codes, and the per-cell control struct
// for the sorted array list. No dependencies.
`default_nettype none

package sal_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned RES_W  = 5;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // request codes
  localparam logic [REQ_W-1:0] OP_INS_SORT  = 3'd0;
  localparam logic [REQ_W-1:0] OP_INS_HEAD  = 3'd1;
  localparam logic [REQ_W-1:0] OP_SEARCH    = 3'd2;
  localparam logic [REQ_W-1:0] OP_DEL_FIRST = 3'd3;
  localparam logic [REQ_W-1:0] OP_DEL_ALL   = 3'd4;
  localparam logic [REQ_W-1:0] OP_CLEAR     = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

  // broadcast to every cell of the row
  typedef struct packed {
    logic capture;  // load compare flags against the broadcast value
    logic head;     // head insert: no entry counts as less or equal
    logic insert;   // open a gap and place the broadcast value
    logic remove;   // close the gap at the first match
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: hdl/sorted_array_list.sv
// sorted_array_list: top level; request sequencer driving a row of sal_cell slots.
// Depends on sal_pkg and sal_cell.
`default_nettype none

// Fixed-capacity list of signed 32-bit values (DEPTH slots) supporting sorted insert,
// head insert, search, delete-first, delete-all and clear. A request is taken when
// start is high and busy is low; one result appears on the result ports for exactly
// one cycle with done_o high, and the receiver cannot hold it off. Each request
// compares across the row and then shifts, and no new request is taken until its
// result is out. Delete-all repeats the compare-and-shift pair once per removed
// entry. busy stays high until the result has been produced.

module sorted_array_list (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      start,
  output logic                                     busy,
  input  wire  logic [sal_pkg::REQ_W-1:0]          req_type_i,
  input  wire  logic signed [sal_pkg::DATA_W-1:0]  value_i,
  output logic                                     done_o,
  output logic [sal_pkg::STAT_W-1:0]               status_o,
  output logic                                     found_o,
  output logic [sal_pkg::RES_W-1:0]                removed_o,
  output logic [sal_pkg::RES_W-1:0]                count_o,
  output logic                                     full_res_o,
  output logic                                     empty_res_o
);
  import sal_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY
  } state_e;

  state_e                   state_q, state_d;
  logic [REQ_W-1:0]         op_q, op_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CNT_W-1:0]         removed_q, removed_d;
  logic                     done_q, done_d;
  logic [STAT_W-1:0]        status_q, status_d;
  logic                     found_q, found_d;
  logic [RES_W-1:0]         rem_res_q, rem_res_d;
  logic [RES_W-1:0]         cnt_res_q, cnt_res_d;
  logic                     full_q, full_d;
  logic                     empty_q, empty_d;

  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] cmp_val;
  logic [DEPTH-1:0]         occ;
  logic signed [DATA_W-1:0] ent_w [DEPTH];
  logic [DEPTH-1:0]         le_w;
  logic [DEPTH-1:0]         le_any_w;
  logic [DEPTH-1:0]         eq_any_w;
  logic                     any_eq;
  logic                     is_full;

  assign busy    = (state_q != S_IDLE);
  assign cmp_val = (state_q == S_IDLE) ? value_i : val_q;
  assign any_eq  = eq_any_w[DEPTH-1];
  assign is_full = (count_q == CNT_W'(DEPTH));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occ[i] = (CNT_W'(i) < count_q);
    end
  end

  // ---------------------------------------------------------------------------
  // cell row
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] below_ent;
    logic signed [DATA_W-1:0] above_ent;
    logic                     le_below;
    logic                     le_above_any;
    logic                     eq_below_any;

    if (i == 0) begin : g_bottom
      // a virtual slot below the row always compares less or equal
      assign below_ent    = '0;
      assign le_below     = 1'b1;
      assign eq_below_any = 1'b0;
    end else begin : g_mid_lo
      assign below_ent    = ent_w[i-1];
      assign le_below     = le_w[i-1];
      assign eq_below_any = eq_any_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_top
      assign above_ent    = '0;
      assign le_above_any = 1'b0;
    end else begin : g_mid_hi
      assign above_ent    = ent_w[i+1];
      assign le_above_any = le_any_w[i+1];
    end

    sal_cell u_cell (
      .clk_i          (clk_i),
      .ctl_i          (ctl),
      .cmp_val_i      (cmp_val),
      .occ_i          (occ[i]),
      .below_ent_i    (below_ent),
      .above_ent_i    (above_ent),
      .le_below_i     (le_below),
      .le_above_any_i (le_above_any),
      .eq_below_any_i (eq_below_any),
      .ent_o          (ent_w[i]),
      .le_o           (le_w[i]),
      .le_any_o       (le_any_w[i]),
      .eq_any_o       (eq_any_w[i])
    );
  end

  // ---------------------------------------------------------------------------
  // request sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    logic              emit;
    logic [STAT_W-1:0] st;
    logic              fnd;
    logic [CNT_W-1:0]  rem;

    emit      = 1'b0;
    st        = ST_OK;
    fnd       = 1'b0;
    rem       = '0;
    state_d   = state_q;
    op_d      = op_q;
    val_d     = val_q;
    count_d   = count_q;
    removed_d = removed_q;
    done_d    = 1'b0;
    status_d  = status_q;
    found_d   = found_q;
    rem_res_d = rem_res_q;
    cnt_res_d = cnt_res_q;
    full_d    = full_q;
    empty_d   = empty_q;
    ctl       = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d        = req_type_i;
          val_d       = value_i;
          removed_d   = '0;
          ctl.capture = 1'b1;
          ctl.head    = (req_type_i == OP_INS_HEAD);
          state_d     = S_APPLY;
        end
      end
      S_EVAL: begin
        ctl.capture = 1'b1;
        state_d     = S_APPLY;
      end
      S_APPLY: begin
        emit = 1'b1;
        case (op_q)
          OP_INS_SORT, OP_INS_HEAD: begin
            if (is_full) begin
              st = ST_FULL;
            end else begin
              ctl.insert = 1'b1;
              count_d    = count_q + CNT_W'(1);
            end
          end
          OP_SEARCH: begin
            fnd = any_eq;
            st  = any_eq ? ST_OK : ST_NOT_FOUND;
          end
          OP_DEL_FIRST: begin
            fnd = any_eq;
            st  = any_eq ? ST_OK : ST_NOT_FOUND;
            if (any_eq) begin
              ctl.remove = 1'b1;
              count_d    = count_q - CNT_W'(1);
              rem        = CNT_W'(1);
            end
          end
          OP_DEL_ALL: begin
            if (any_eq) begin
              // drop one match and compare again
              ctl.remove = 1'b1;
              count_d    = count_q - CNT_W'(1);
              removed_d  = removed_q + CNT_W'(1);
              state_d    = S_EVAL;
              emit       = 1'b0;
            end else begin
              fnd = (removed_q != '0);
              st  = fnd ? ST_OK : ST_NOT_FOUND;
              rem = removed_q;
            end
          end
          OP_CLEAR: begin
            rem     = count_q;
            count_d = '0;
          end
          default: begin
          end
        endcase
        if (emit) begin
          done_d    = 1'b1;
          status_d  = st;
          found_d   = fnd;
          rem_res_d = RES_W'(rem);
          cnt_res_d = RES_W'(count_d);
          full_d    = (count_d == CNT_W'(DEPTH));
          empty_d   = (count_d == '0);
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= '0;
      val_q     <= '0;
      count_q   <= '0;
      removed_q <= '0;
      done_q    <= 1'b0;
      status_q  <= ST_OK;
      found_q   <= 1'b0;
      rem_res_q <= '0;
      cnt_res_q <= '0;
      full_q    <= 1'b0;
      empty_q   <= 1'b1;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      val_q     <= val_d;
      count_q   <= count_d;
      removed_q <= removed_d;
      done_q    <= done_d;
      status_q  <= status_d;
      found_q   <= found_d;
      rem_res_q <= rem_res_d;
      cnt_res_q <= cnt_res_d;
      full_q    <= full_d;
      empty_q   <= empty_d;
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign found_o     = found_q;
  assign removed_o   = rem_res_q;
  assign count_o     = cnt_res_q;
  assign full_res_o  = full_q;
  assign empty_res_o = empty_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_done_after_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == S_APPLY))
    else $error("result strobe without a finishing apply step");

  a_accept_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_q))
    else $error("accepted request did not raise busy");

  a_full_insert_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPLY && is_full && (op_q == OP_INS_SORT || op_q == OP_INS_HEAD))
      |=> (count_q == $past(count_q) && status_q == ST_FULL))
    else $error("insert into a full list changed the count");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (count_q <= CNT_W'(DEPTH) && empty_q == (count_q == '0)))
    else $error("count out of range or empty flag inconsistent");

endmodule

`default_nettype wire

// File: hdl/sal_cell.sv
// sal_cell: one slot of the list row; holds an entry and its compare flags and
// passes entries and flag chains to its neighbors. Depends on sal_pkg.
`default_nettype none

module sal_cell (
  input  wire                              clk_i,
  input  wire  sal_pkg::cell_ctl_t         ctl_i,
  input  wire  logic signed [sal_pkg::DATA_W-1:0] cmp_val_i,
  input  wire                              occ_i,
  input  wire  logic signed [sal_pkg::DATA_W-1:0] below_ent_i,
  input  wire  logic signed [sal_pkg::DATA_W-1:0] above_ent_i,
  input  wire                              le_below_i,
  input  wire                              le_above_any_i,
  input  wire                              eq_below_any_i,
  output logic signed [sal_pkg::DATA_W-1:0] ent_o,
  output logic                             le_o,
  output logic                             le_any_o,
  output logic                             eq_any_o
);
  import sal_pkg::*;

  logic signed [DATA_W-1:0] ent_q;
  logic                     le_q;
  logic                     eq_q;
  logic                     take_below;
  logic                     place;

  // suffix chain of "entry <= value" going down, prefix chain of matches going up
  assign le_any_o = le_q | le_above_any_i;
  assign eq_any_o = eq_q | eq_below_any_i;

  // the new value lands just above the highest entry not greater than it
  assign take_below = !(le_below_i | le_any_o);
  assign place      = le_below_i & !le_any_o;

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      le_q <= occ_i & !ctl_i.head & (ent_q <= cmp_val_i);
      eq_q <= occ_i & (ent_q == cmp_val_i);
    end
    if (ctl_i.insert) begin
      if (take_below) begin
        ent_q <= below_ent_i;
      end else if (place) begin
        ent_q <= cmp_val_i;
      end
    end else if (ctl_i.remove && eq_any_o) begin
      ent_q <= above_ent_i;
    end
  end

  assign ent_o = ent_q;
  assign le_o  = le_q;

endmodule

`default_nettype wire

// File: tb/sal_list_checker.sv
// sal_list_checker: watches the request and result channels of sorted_array_list,
// predicts every reply from its own copy of the list and compares. Depends on sal_pkg.
`timescale 1ns / 100ps

module sal_list_checker (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      start_i,
  input  wire                                      busy_i,
  input  wire  logic [sal_pkg::REQ_W-1:0]          req_type_i,
  input  wire  logic signed [sal_pkg::DATA_W-1:0]  value_i,
  input  wire                                      done_i,
  input  wire  logic [sal_pkg::STAT_W-1:0]         status_i,
  input  wire                                      found_i,
  input  wire  logic [sal_pkg::RES_W-1:0]          removed_i,
  input  wire  logic [sal_pkg::RES_W-1:0]          count_i,
  input  wire                                      full_res_i,
  input  wire                                      empty_res_i,
  output int                                       mismatches_o,
  output int                                       replies_due_o
);

  import sal_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              found;
    logic [RES_W-1:0]  removed;
    logic [RES_W-1:0]  count;
    logic              full;
    logic              empty;
  } list_reply_t;

  logic signed [DATA_W-1:0] shadow_cells [DEPTH];
  int unsigned              shadow_held;
  list_reply_t              list_replies_due [$];
  int                       mismatch_total;

  function automatic list_reply_t apply_list_request(input logic [REQ_W-1:0] op,
                                                     input logic signed [DATA_W-1:0] v);
    list_reply_t r;
    int unsigned i;
    int unsigned kept;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_INS_SORT, OP_INS_HEAD: begin
        if (shadow_held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          i = shadow_held;
          // equal entries stay below the new value on a sorted insert
          while (i > 0 && (op == OP_INS_HEAD || shadow_cells[i-1] > v)) begin
            shadow_cells[i] = shadow_cells[i-1];
            i--;
          end
          shadow_cells[i] = v;
          shadow_held++;
        end
      end
      OP_SEARCH: begin
        for (i = 0; i < shadow_held; i++)
          if (shadow_cells[i] == v) r.found = 1'b1;
      end
      OP_DEL_FIRST: begin
        for (i = 0; i < shadow_held; i++) begin
          if (!r.found && shadow_cells[i] == v) r.found = 1'b1;
          else if (r.found) shadow_cells[i-1] = shadow_cells[i];
        end
        if (r.found) begin
          r.removed = RES_W'(1);
          shadow_held--;
        end
      end
      OP_DEL_ALL: begin
        kept = 0;
        for (i = 0; i < shadow_held; i++) begin
          if (shadow_cells[i] != v) begin
            shadow_cells[kept] = shadow_cells[i];
            kept++;
          end
        end
        r.removed = RES_W'(shadow_held - kept);
        r.found   = (kept != shadow_held);
        shadow_held = kept;
      end
      OP_CLEAR: begin
        r.removed = RES_W'(shadow_held);
        shadow_held = 0;
      end
      default: ;  // unused codes leave the list alone
    endcase
    if ((op == OP_SEARCH || op == OP_DEL_FIRST || op == OP_DEL_ALL) && !r.found)
      r.status = ST_NOT_FOUND;
    r.count = RES_W'(shadow_held);
    r.full  = (shadow_held == DEPTH);
    r.empty = (shadow_held == 0);
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_reply_t want;
    if (!rst_ni) begin
      shadow_held = 0;
      list_replies_due.delete();
      mismatch_total = 0;
      mismatches_o  <= 0;
      replies_due_o <= 0;
    end else begin
      // a reply leaving at this edge belongs to an earlier request
      if (done_i) begin
        if (list_replies_due.size() == 0) begin
          $display("%0t: reply with no request waiting, expected none, actual status=%0d",
                   $time, status_i, " count=%0d", count_i);
          mismatch_total++;
        end else begin
          want = list_replies_due.pop_front();
          check_field("status", want.status, status_i);
          check_field("found", want.found, found_i);
          check_field("removed", want.removed, removed_i);
          check_field("count", want.count, count_i);
          check_field("full_res", want.full, full_res_i);
          check_field("empty_res", want.empty, empty_res_i);
        end
      end
      if (start_i && !busy_i)
        list_replies_due.push_back(apply_list_request(req_type_i, value_i));
      mismatches_o  <= mismatch_total;
      replies_due_o <= list_replies_due.size();
    end
  end

endmodule

// File: tb/tb_sorted_array_list.sv
// tb_sorted_array_list: drives directed and random list requests into sorted_array_list
// and gives the verdict. Depends on sal_pkg, sorted_array_list and sal_list_checker.
`timescale 1ns / 100ps

module tb_sorted_array_list;

  import sal_pkg::*;

  localparam logic [REQ_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [REQ_W-1:0] OP_RSVD_7 = 3'd7;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SEGMENTS     = 16;
  localparam int SEG_ITEMS    = 100;
  localparam int TAIL_CYCLES  = 2 + 2 * DEPTH + 8;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic [REQ_W-1:0]         req_type = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     busy;
  logic                     done;
  logic [STAT_W-1:0]        status;
  logic                     found;
  logic [RES_W-1:0]         removed;
  logic [RES_W-1:0]         count;
  logic                     full_res;
  logic                     empty_res;
  int                       mismatches;
  int                       replies_due;
  int                       cycles = 0;

  logic signed [DATA_W-1:0] recent_values [8];

  sorted_array_list dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_type_i  (req_type),
    .value_i     (value),
    .done_o      (done),
    .status_o    (status),
    .found_o     (found),
    .removed_o   (removed),
    .count_o     (count),
    .full_res_o  (full_res),
    .empty_res_o (empty_res)
  );

  sal_list_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .req_type_i    (req_type),
    .value_i       (value),
    .done_i        (done),
    .status_i      (status),
    .found_i       (found),
    .removed_i     (removed),
    .count_i       (count),
    .full_res_i    (full_res),
    .empty_res_i   (empty_res),
    .mismatches_o  (mismatches),
    .replies_due_o (replies_due)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_sorted_array_list NOT OK");
      $finish;
    end
  end

  // returns at the edge that takes the request, start still high
  task automatic issue(input logic [REQ_W-1:0] op, input logic signed [DATA_W-1:0] v);
    start    <= 1'b1;
    req_type <= op;
    value    <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic maybe_idle(input bit allow);
    if (allow && $urandom_range(0, 99) < 29) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    do @(posedge clk_i); while (replies_due != 0);
  endtask

  // few distinct values so that duplicates, hits and fills are common
  function automatic logic signed [DATA_W-1:0] pick_value(input bit prefer_held);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (prefer_held && sel < 60) return recent_values[$urandom_range(0, 7)];
    if (sel < 30) return 32'sh8000_0000;
    if (sel < 38) return 32'sh7fff_ffff;
    if (sel < 70) return $signed(DATA_W'($urandom_range(0, 6)) - 3);
    return $signed($urandom());
  endfunction

  function automatic logic [REQ_W-1:0] pick_op(input int unsigned mode);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 1) return ($urandom_range(0, 1) != 0) ? OP_RSVD_6 : OP_RSVD_7;
    if (sel < 3) return OP_CLEAR;
    case (mode)
      0: begin  // grow towards full
        if (sel < 55) return OP_INS_SORT;
        if (sel < 75) return OP_INS_HEAD;
        if (sel < 88) return OP_SEARCH;
        if (sel < 95) return OP_DEL_FIRST;
        return OP_DEL_ALL;
      end
      1: begin  // shrink towards empty
        if (sel < 18) return OP_INS_SORT;
        if (sel < 25) return OP_INS_HEAD;
        if (sel < 45) return OP_SEARCH;
        if (sel < 75) return OP_DEL_FIRST;
        return OP_DEL_ALL;
      end
      default: begin
        if (sel < 30) return OP_INS_SORT;
        if (sel < 45) return OP_INS_HEAD;
        if (sel < 65) return OP_SEARCH;
        if (sel < 85) return OP_DEL_FIRST;
        return OP_DEL_ALL;
      end
    endcase
  endfunction

  initial begin
    logic [REQ_W-1:0]         op;
    logic signed [DATA_W-1:0] v;
    bit                       allow_idle;
    for (int k = 0; k < 8; k++) recent_values[k] = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list, unused codes, signed extremes, equals, head order, adjacent duplicates
    issue(OP_CLEAR, 32'sd0);
    issue(OP_SEARCH, 32'sd0);
    issue(OP_DEL_FIRST, 32'sd5);
    issue(OP_DEL_ALL, 32'sd5);
    issue(OP_RSVD_6, 32'sh7fff_ffff);
    issue(OP_RSVD_7, 32'sh8000_0000);
    issue(OP_INS_SORT, 32'sd0);
    issue(OP_INS_SORT, 32'sh8000_0000);
    issue(OP_INS_SORT, 32'sh7fff_ffff);
    issue(OP_INS_SORT, 32'sd0);
    issue(OP_INS_SORT, -32'sd1);
    issue(OP_INS_HEAD, 32'sd7);
    issue(OP_INS_HEAD, 32'sh8000_0000);
    issue(OP_SEARCH, 32'sh7fff_ffff);
    issue(OP_SEARCH, 32'sd12345);
    issue(OP_DEL_FIRST, 32'sd0);
    issue(OP_DEL_ALL, 32'sd5);
    issue(OP_INS_SORT, 32'sd0);
    issue(OP_INS_SORT, 32'sd0);
    issue(OP_DEL_ALL, 32'sd0);
    issue(OP_RSVD_7, 32'sd0);
    issue(OP_CLEAR, 32'sd0);
    drain();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      allow_idle = !(seg == 6 || seg == 7);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        op = pick_op(seg % 3);
        v  = pick_value(op != OP_INS_SORT && op != OP_INS_HEAD);
        if (op == OP_INS_SORT || op == OP_INS_HEAD)
          recent_values[$urandom_range(0, 7)] = v;
        issue(op, v);
        maybe_idle(allow_idle);
      end
      if (seg % 4 == 3) drain();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && replies_due == 0) begin
      $display("tb_sorted_array_list OK");
    end else begin
      $display("tb_sorted_array_list NOT OK");
    end
    $finish;
  end

endmodule
